/* design/ccfd_pkg.sv */
// Package for the COBS frame decoder with CRC-32 check.
// Holds the result kind codes, the result struct and the byte-wide CRC update.
// No dependencies.
package ccfd_pkg;

  // default capacity of the decoded frame in bytes
  localparam int unsigned BufferBytesDefault = 128;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [7:0]  CodeMax = 8'hFF;
  localparam logic [7:0]  TailLen = 8'd4;

  typedef enum logic [2:0] {
    KindPayload  = 3'd0,
    KindGood     = 3'd1,
    KindOverflow = 3'd2,
    KindShort    = 3'd3,
    KindCrcBad   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [6:0]  len;
  } result_t;

  // reflected crc-32, one byte folded in, bit at a time
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/ccfd_core.sv */
// Decode core: COBS block tracking, four-byte tail delay line and CRC-32.
// Updates frame state on each advanced beat and forms at most one result.
// Depends on ccfd_pkg.
module ccfd_core import ccfd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [7:0] BufLimit = 8'(BUFFER_BYTES);

  logic        in_frame_q, in_frame_d;
  logic [7:0]  block_left_q, block_left_d;
  logic [7:0]  last_code_q, last_code_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  tail_q [4];
  logic [7:0]  tail_d [4];
  logic [31:0] crc_q, crc_d;

  logic        do_push;
  logic [7:0]  push_byte;
  logic [31:0] held;

  assign held = {tail_q[0], tail_q[1], tail_q[2], tail_q[3]};

  // frame state update and result selection
  always_comb begin
    in_frame_d   = in_frame_q;
    block_left_d = block_left_q;
    last_code_d  = last_code_q;
    count_d      = count_q;
    tail_d       = tail_q;
    crc_d        = crc_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KindPayload, data: 8'h00, len: 7'h00};
    do_push      = 1'b0;
    push_byte    = 8'h00;

    if (!in_frame_q) begin
      // waiting for a code byte, zeros are idle fill
      if (byte_i != 8'h00) begin
        in_frame_d   = 1'b1;
        last_code_d  = byte_i;
        block_left_d = byte_i - 8'd1;
        count_d      = 8'd0;
        tail_d       = '{default: 8'h00};
        crc_d        = CrcInit;
      end
    end else if (block_left_q != 8'd0) begin
      // literal data byte
      block_left_d = block_left_q - 8'd1;
      do_push      = 1'b1;
      push_byte    = byte_i;
    end else if (byte_i == 8'h00) begin
      // frame delimiter at a block boundary
      res_valid_o = 1'b1;
      if (count_q < TailLen) begin
        res_o.kind = KindShort;
      end else if ((crc_q ^ CrcInit) == held) begin
        res_o.kind = KindGood;
        res_o.len  = 7'(count_q - TailLen);
      end else begin
        res_o.kind = KindCrcBad;
      end
      in_frame_d   = 1'b0;
      block_left_d = 8'd0;
      last_code_d  = 8'd0;
      count_d      = 8'd0;
      tail_d       = '{default: 8'h00};
      crc_d        = CrcInit;
    end else begin
      // next code byte, implicit zero unless previous code was the maximum
      last_code_d  = byte_i;
      block_left_d = byte_i - 8'd1;
      do_push      = (last_code_q < CodeMax);
      push_byte    = 8'h00;
    end

    // push one decoded byte through the tail delay line
    if (do_push) begin
      if (count_q >= BufLimit) begin
        res_valid_o  = 1'b1;
        res_o.kind   = KindOverflow;
        in_frame_d   = 1'b0;
        block_left_d = 8'd0;
        last_code_d  = 8'd0;
        count_d      = 8'd0;
        tail_d       = '{default: 8'h00};
        crc_d        = CrcInit;
      end else begin
        tail_d[0] = tail_q[1];
        tail_d[1] = tail_q[2];
        tail_d[2] = tail_q[3];
        tail_d[3] = push_byte;
        count_d   = count_q + 8'd1;
        if (count_q >= TailLen) begin
          crc_d       = crc_fold(crc_q, tail_q[0]);
          res_valid_o = 1'b1;
          res_o.kind  = KindPayload;
          res_o.data  = tail_q[0];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      block_left_q <= 8'd0;
      last_code_q  <= 8'd0;
      count_q      <= 8'd0;
      tail_q       <= '{default: 8'h00};
      crc_q        <= CrcInit;
    end else if (advance_i) begin
      in_frame_q   <= in_frame_d;
      block_left_q <= block_left_d;
      last_code_q  <= last_code_d;
      count_q      <= count_d;
      tail_q       <= tail_d;
      crc_q        <= crc_d;
    end
  end

  // overflow always drops the frame
  a_overflow_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_o.kind == KindOverflow |=> !in_frame_q && count_q == 8'd0)
    else $error("overflow did not clear the frame");

  // decoded count stays within the buffer
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= BufLimit)
    else $error("decoded count beyond buffer");

  // payload only leaves once the tail line is full
  a_payload_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_o.kind == KindPayload |-> count_q >= TailLen && in_frame_q)
    else $error("payload before tail line filled");

  // a good frame had at least the crc bytes
  a_good_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && res_o.kind == KindGood |-> count_q >= TailLen)
    else $error("good frame shorter than crc");

endmodule

/* design/ccfd_out_reg.sv */
// Result register for the COBS frame decoder output channel.
// Holds one result beat until taken and reports free space upstream.
// Depends on ccfd_pkg.
module ccfd_out_reg import ccfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q;
  result_t data_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule

/* design/cobs_crc32_frame_decoder.sv */
// COBS frame decoder with CRC-32 check, top level.
// An accepted byte passes through the input register and the decode core into
// the result register. Throughput: one encoded byte per cycle while the result
// register has space, bound by the input register and the result register.
// Reset clears the input and result valid flags and the frame state (idle,
// CRC all ones). Depends on ccfd_pkg, ccfd_core, ccfd_out_reg.
module cobs_crc32_frame_decoder import ccfd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [6:0] frame_length_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       space;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance    = in_valid_q && space;
  assign rx_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // decode core
  ccfd_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .byte_i     (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register
  ccfd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_res)
  );

  assign kind_o         = out_res.kind;
  assign data_byte_o    = out_res.data;
  assign frame_length_o = out_res.len;

endmodule

/* tb/ccfd_checker.sv */
`timescale 1ns / 100ps
// Checker for the COBS frame decoder with CRC-32 check: watches both channels,
// predicts every result with its own frame decoder and compares them in order.
// Depends on ccfd_pkg for the result kinds, the result struct and the constants.
module ccfd_checker import ccfd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic       rx_ready_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] kind_i,
  input  logic [7:0] data_byte_i,
  input  logic [6:0] frame_length_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         good_frames_o,
  output int         error_frames_o,
  output int         payload_beats_o
);

  // keep the log short when the block is badly off
  localparam int ReportLines = 200;

  // predicted frame state
  logic        frame_open;
  logic [7:0]  block_rem;
  logic [7:0]  prev_code;
  logic [7:0]  dec_count;
  logic [7:0]  tail [4];
  logic [31:0] crc_acc;

  result_t predicted_results [$];

  task automatic report(input string msg);
    if (fail_count_o < ReportLines) $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic clear_frame();
    frame_open = 1'b0;
    block_rem  = '0;
    prev_code  = '0;
    dec_count  = '0;
    for (int i = 0; i < 4; i++) tail[i] = '0;
    crc_acc = CrcInit;
  endtask

  task automatic add_result(input kind_e k, input logic [7:0] d, input logic [6:0] n);
    result_t r;
    r.kind = k;
    r.data = d;
    r.len  = n;
    predicted_results.push_back(r);
  endtask

  // one decoded byte into the tail window; the byte pushed out is payload
  task automatic decode_byte(input logic [7:0] b);
    logic [7:0]  leaving;
    logic [31:0] c;
    if (dec_count >= BUFFER_BYTES) begin
      clear_frame();
      add_result(KindOverflow, 8'h00, 7'd0);
    end else begin
      leaving = tail[0];
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = tail[3];
      tail[3] = b;
      dec_count = dec_count + 8'd1;
      if (dec_count > TailLen) begin
        // reflected crc, fed lsb first
        c = crc_acc;
        for (int i = 0; i < 8; i++) begin
          if (c[0] ^ leaving[i]) c = {1'b0, c[31:1]} ^ CrcPoly;
          else c = {1'b0, c[31:1]};
        end
        crc_acc = c;
        add_result(KindPayload, leaving, 7'd0);
      end
    end
  endtask

  // one received byte of the encoded stream
  task automatic decode_rx_byte(input logic [7:0] b);
    logic [31:0] held;
    logic [7:0]  n;
    logic [7:0]  payload_len;
    kind_e       status;
    if (!frame_open) begin
      // zeros between frames are dropped, anything else opens a frame
      if (b != 8'h00) begin
        clear_frame();
        frame_open = 1'b1;
        prev_code  = b;
        block_rem  = b - 8'd1;
      end
    end else if (block_rem != 8'd0) begin
      // literal byte, a zero here included
      block_rem = block_rem - 8'd1;
      decode_byte(b);
    end else if (b == 8'h00) begin
      // delimiter at a block boundary closes the frame
      n = dec_count;
      held = {tail[0], tail[1], tail[2], tail[3]};
      payload_len = n - TailLen;
      if (n < TailLen) status = KindShort;
      else if ((crc_acc ^ CrcInit) == held) status = KindGood;
      else status = KindCrcBad;
      clear_frame();
      add_result(status, 8'h00, (status == KindGood) ? payload_len[6:0] : 7'd0);
    end else begin
      // next code byte; the zero between blocks is dropped after a full block
      if (prev_code < CodeMax) decode_byte(8'h00);
      if (frame_open) begin
        prev_code = b;
        block_rem = b - 8'd1;
      end
    end
  endtask

  // compare accepted results, then predict from the accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_frame();
      predicted_results.delete();
      fail_count_o    = 0;
      good_frames_o   = 0;
      error_frames_o  = 0;
      payload_beats_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          report($sformatf("result beat with nothing pending: kind %0d data %02h len %0d",
                           kind_i, data_byte_i, frame_length_i));
        end else begin
          want = predicted_results.pop_front();
          if (kind_i !== want.kind)
            report($sformatf("kind %0d, predicted %0d", kind_i, want.kind));
          if (data_byte_i !== want.data)
            report($sformatf("data_byte %02h, predicted %02h (kind %0d)",
                             data_byte_i, want.data, want.kind));
          if (frame_length_i !== want.len)
            report($sformatf("frame_length %0d, predicted %0d (kind %0d)",
                             frame_length_i, want.len, want.kind));
          if (want.kind == KindPayload) payload_beats_o++;
          else if (want.kind == KindGood) good_frames_o++;
          else error_frames_o++;
        end
      end
      if (rx_valid_i && rx_ready_i) decode_rx_byte(rx_byte_i);
    end
    pending_o = predicted_results.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the COBS frame decoder with CRC-32 check: builds encoded
// frames, drives the byte channel and the result stall pattern, gives the verdict.
// Depends on ccfd_pkg, cobs_crc32_frame_decoder and ccfd_checker.
module tb;
  import ccfd_pkg::*;

  localparam int unsigned BufferBytes = BufferBytesDefault;
  localparam int ItemTarget  = 550;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 10;

  typedef enum int {
    FrameGood,
    FrameCrcBad,
    FrameShort,
    FrameOverflow,
    FrameBroken,
    FrameNoise,
    FrameCodeMax
  } frame_e;

  typedef enum int {
    ReadyAlways,
    ReadyMostly,
    ReadyRarely,
    ReadyPeriodic
  } ready_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       rx_valid_i  = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [7:0] data_byte_o;
  logic [6:0] frame_length_o;

  int fail_count;
  int pending;
  int good_frames;
  int error_frames;
  int payload_beats;
  int beats_sent  = 0;
  int frames_sent = 0;
  int idle_cycles = 0;
  int burst_left  = 0;

  ready_mode_e ready_mode = ReadyAlways;
  int          ready_left = 0;
  int          ready_tick = 0;

  logic [7:0] raw_q [$];
  logic [7:0] enc_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cobs_crc32_frame_decoder #(
    .BUFFER_BYTES(BufferBytes)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .frame_length_o(frame_length_o)
  );

  ccfd_checker #(
    .BUFFER_BYTES(BufferBytes)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_i     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .data_byte_i    (data_byte_o),
    .frame_length_i (frame_length_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .good_frames_o  (good_frames),
    .error_frames_o (error_frames),
    .payload_beats_o(payload_beats)
  );

  // result stall pattern: phases of random length, each with its own mode
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(10, 80);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      ReadyAlways: out_ready_i <= 1'b1;
      ReadyMostly: out_ready_i <= ($urandom_range(0, 3) != 0);
      ReadyRarely: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= (ready_tick % 5 == 0);
    endcase
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("timeout: no beat on either channel for %0d cycles", IdleLimit);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // payload bytes lean toward zero and 0xff so blocks split often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // append the finalized crc-32, big-endian
  task automatic append_crc();
    logic [31:0] c;
    c = CrcInit;
    foreach (raw_q[i]) c = crc_fold(c, raw_q[i]);
    c = c ^ CrcInit;
    raw_q.push_back(c[31:24]);
    raw_q.push_back(c[23:16]);
    raw_q.push_back(c[15:8]);
    raw_q.push_back(c[7:0]);
  endtask

  // cobs encode raw_q into enc_q, delimiter included
  task automatic encode_frame();
    int         code_at;
    logic [7:0] code;
    enc_q.delete();
    enc_q.push_back(8'h00);
    code_at = 0;
    code = 8'd1;
    foreach (raw_q[i]) begin
      if (raw_q[i] == 8'h00) begin
        enc_q[code_at] = code;
        code_at = enc_q.size();
        enc_q.push_back(8'h00);
        code = 8'd1;
      end else begin
        enc_q.push_back(raw_q[i]);
        code++;
        if (code == CodeMax) begin
          enc_q[code_at] = code;
          code_at = enc_q.size();
          enc_q.push_back(8'h00);
          code = 8'd1;
        end
      end
    end
    enc_q[code_at] = code;
    enc_q.push_back(8'h00);
  endtask

  // one beat, with the sender idling between bursts
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap != 0) begin
        rx_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    beats_sent++;
  endtask

  task automatic send_enc();
    foreach (enc_q[i]) send_byte(enc_q[i]);
    frames_sent++;
  endtask

  // hold off until every predicted result has come out
  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_e kind, input int len);
    int pos;
    raw_q.delete();
    case (kind)
      FrameNoise: begin
        enc_q.delete();
        repeat (len) enc_q.push_back(8'($urandom_range(0, 255)));
        enc_q.push_back(8'h00);
      end
      FrameCodeMax: begin
        // block opened by the maximum code, runs into the buffer limit
        enc_q.delete();
        enc_q.push_back(CodeMax);
        repeat (len) enc_q.push_back(8'($urandom_range(1, 255)));
        enc_q.push_back(8'h00);
      end
      FrameShort: begin
        repeat (len) raw_q.push_back(pick_byte());
        encode_frame();
      end
      default: begin
        repeat (len) raw_q.push_back(pick_byte());
        append_crc();
        if (kind == FrameCrcBad) begin
          pos = $urandom_range(0, raw_q.size() - 1);
          raw_q[pos] = raw_q[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        encode_frame();
        if (kind == FrameBroken) begin
          pos = $urandom_range(1, enc_q.size() - 2);
          if ($urandom_range(0, 1) == 0) begin
            enc_q[pos] = enc_q[pos] ^ 8'(1 << $urandom_range(0, 7));
          end else begin
            // cut the frame short and close it early
            while (enc_q.size() > pos) void'(enc_q.pop_back());
            enc_q.push_back(8'h00);
          end
        end
      end
    endcase
    repeat ($urandom_range(0, 2)) enc_q.push_front(8'h00);
    send_enc();
  endtask

  initial begin
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored zeros, frame with no data, zero inside a block, short frames
    enc_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00};
    send_enc();
    // empty payload: the crc bytes alone
    send_frame(FrameGood, 0);
    // payload of the two extreme byte values
    raw_q = '{8'h00, 8'hFF};
    append_crc();
    encode_frame();
    send_enc();
    // one flipped crc bit
    raw_q = '{8'h80};
    append_crc();
    raw_q[4] = raw_q[4] ^ 8'h01;
    encode_frame();
    send_enc();
    wait_drained();

    // largest good frame, buffer overflow, maximum code block past the limit
    send_frame(FrameGood, BufferBytes - 4);
    send_frame(FrameOverflow, BufferBytes - 3);
    send_frame(FrameCodeMax, BufferBytes + 2);
    wait_drained();

    // random frames, mostly well formed, until the byte budget is spent
    while (beats_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_frame(FrameGood, ($urandom_range(0, 9) == 0) ?
                   $urandom_range(17, BufferBytes - 4) : $urandom_range(0, 16));
      else if (r < 67) send_frame(FrameCrcBad, $urandom_range(0, 16));
      else if (r < 75) send_frame(FrameShort, $urandom_range(0, 3));
      else if (r < 78) send_frame(FrameOverflow, $urandom_range(BufferBytes - 3, BufferBytes + 2));
      else if (r < 92) send_frame(FrameBroken, $urandom_range(1, 16));
      else send_frame(FrameNoise, $urandom_range(1, 6));
      if ($urandom_range(0, 14) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("drove %0d encoded bytes in %0d frames, ragged ones included", beats_sent,
             frames_sent);
    $display("checked %0d payload bytes, %0d good frames and %0d error statuses",
             payload_beats, good_frames, error_frames);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
